// ----- design/sfpsc_pkg.sv -----
// ----------------------------------------------------------------------------
// sfpsc_pkg: shared types and constants of the sync frame parser
// Event codes, register indexes, reset values and the result layout.
// ----------------------------------------------------------------------------
`default_nettype none

package sfpsc_pkg;

    // largest payload length accepted in the length byte
    localparam logic [7:0] MAX_PAYLOAD = 8'd254;

    // reset values of the configuration registers
    localparam logic [7:0] START_BYTE_RST  = 8'd250;
    localparam logic [7:0] BUS_ID_BYTE_RST = 8'd255;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_START_BYTE  = 1'b0,
        CFG_BUS_ID_BYTE = 1'b1
    } cfg_index_t;

    // result event codes
    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_PAYLOAD  = 3'd1,
        EV_GOOD     = 3'd2,
        EV_BAD_BID  = 3'd3,
        EV_TOO_LONG = 3'd4,
        EV_BAD_SUM  = 3'd5
    } evt_code_t;

    // one result, event code in the lowest bits
    typedef struct packed {
        logic [7:0] frame_length;
        logic [7:0] message_id;
        logic [7:0] payload_index;
        logic [7:0] payload_byte;
        evt_code_t  event_res;
    } result_t;

    localparam int RESULT_W  = $bits(result_t);
    localparam int M_TDATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

`default_nettype wire

// ----- design/sync_frame_parser_sum_check.sv -----
// ----------------------------------------------------------------------------
// sync_frame_parser_sum_check: byte stream frame parser with additive checksum
// Finds frames of start, bus id, message id, length, payload and checksum
// bytes and reports one result transaction per received byte.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one received byte per transaction. m_* returns exactly one
//   result transaction per input byte: event code, payload byte and index
//   (valid on payload events, zero otherwise), and the message id and the
//   declared length of the current frame. Payload bytes may be stored by
//   the consumer and committed on a frame good event.
//   The result is registered and valid in the cycle after the input transaction.
//   Throughput is one byte per cycle while the receiver keeps up: the whole parse
//   step is one state update between the input handshake and the result register.
//   When the receiver stalls, the result register holds and s_tready drops
//   until it is taken; a new byte is accepted in the same cycle the pending
//   result leaves.
//   Reset (aresetn low, synchronous) returns the parser to hunting for the
//   start byte, clears the frame state and loads the register defaults
//   (start byte 250, bus id 255). The user must write registers through
//   cfg_we, cfg_addr, cfg_wdata only while the stream is idle; not enforced.
// ----------------------------------------------------------------------------
`default_nettype none

module sync_frame_parser_sum_check
    import sfpsc_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // configuration write port
    input  wire logic                 cfg_we,
    input  wire logic [0:0]           cfg_addr,
    input  wire logic [7:0]           cfg_wdata,
    // received bytes
    input  wire logic                 s_tvalid,
    output      logic                 s_tready,
    input  wire logic [7:0]           s_tdata,   // [7:0] rx_byte
    // results
    output      logic                 m_tvalid,
    input  wire logic                 m_tready,
    // [2:0] event_res, [10:3] payload_byte, [18:11] payload_index,
    // [26:19] message_id, [34:27] frame_length, rest zero
    output      logic [M_TDATA_W-1:0] m_tdata
);

    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_START = 3'd1,
        PH_BID   = 3'd2,
        PH_MID   = 3'd3,
        PH_DATA  = 3'd4,
        PH_CK    = 3'd5
    } phase_t;

    logic [7:0] start_byte_reg;
    logic [7:0] bus_id_byte_reg;

    phase_t     phase_reg, phase_next;
    logic [7:0] current_id_reg, current_id_next;
    logic [7:0] declared_length_reg, declared_length_next;
    logic [7:0] byte_index_reg, byte_index_next;
    logic [7:0] running_sum_reg, running_sum_next;

    result_t    result_reg, result_next;
    logic       m_tvalid_reg;

    logic       s_accept;
    logic [7:0] index_inc;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W - RESULT_W){1'b0}}, result_reg};
    assign index_inc = byte_index_reg + 8'd1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_byte_reg  <= START_BYTE_RST;
            bus_id_byte_reg <= BUS_ID_BYTE_RST;
        end else if (cfg_we) begin
            unique case (cfg_index_t'(cfg_addr))
                CFG_START_BYTE:  start_byte_reg  <= cfg_wdata;
                CFG_BUS_ID_BYTE: bus_id_byte_reg <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    // parse step for one received byte
    always_comb begin
        phase_next           = phase_reg;
        current_id_next      = current_id_reg;
        declared_length_next = declared_length_reg;
        byte_index_next      = byte_index_reg;
        running_sum_next     = running_sum_reg + s_tdata;
        result_next          = '0;
        result_next.event_res = EV_NONE;

        unique case (phase_reg)
            PH_START: begin
                if (s_tdata != bus_id_byte_reg) begin
                    result_next.event_res = EV_BAD_BID;
                    phase_next = PH_HUNT;
                end else begin
                    phase_next = PH_BID;
                end
            end
            PH_BID: begin
                current_id_next = s_tdata;
                phase_next      = PH_MID;
            end
            PH_MID: begin
                declared_length_next = s_tdata;
                byte_index_next      = 8'd0;
                priority if (s_tdata > MAX_PAYLOAD) begin
                    result_next.event_res = EV_TOO_LONG;
                    phase_next = PH_HUNT;
                end else if (s_tdata == 8'd0) begin
                    phase_next = PH_CK;
                end else begin
                    phase_next = PH_DATA;
                end
            end
            PH_DATA: begin
                result_next.event_res     = EV_PAYLOAD;
                result_next.payload_byte  = s_tdata;
                result_next.payload_index = byte_index_reg;
                byte_index_next           = index_inc;
                if (index_inc >= declared_length_reg) begin
                    phase_next = PH_CK;
                end
            end
            PH_CK: begin
                result_next.event_res = (running_sum_next == 8'd0) ? EV_GOOD : EV_BAD_SUM;
                phase_next = PH_HUNT;
            end
            default: begin
                // hunting: the sum restarts after the start byte
                if (s_tdata == start_byte_reg) begin
                    running_sum_next = 8'd0;
                    phase_next       = PH_START;
                end else begin
                    phase_next = PH_HUNT;
                end
            end
        endcase

        result_next.message_id   = current_id_next;
        result_next.frame_length = declared_length_next;
    end

    // frame state, updated once per accepted byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg           <= PH_HUNT;
            current_id_reg      <= 8'd0;
            declared_length_reg <= 8'd0;
            byte_index_reg      <= 8'd0;
            running_sum_reg     <= 8'd0;
        end else if (s_accept) begin
            phase_reg           <= phase_next;
            current_id_reg      <= current_id_next;
            declared_length_reg <= declared_length_next;
            byte_index_reg      <= byte_index_next;
            running_sum_reg     <= running_sum_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            result_reg <= result_next;
        end
    end

    // payload data only arrives for a legal nonzero length
    assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_DATA |-> (declared_length_reg != 8'd0) &&
                                 (declared_length_reg <= MAX_PAYLOAD))
    else $error("payload phase with illegal declared length");

    // a payload index always lies inside the declared frame
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && result_reg.event_res == EV_PAYLOAD
        |-> result_reg.payload_index < result_reg.frame_length)
    else $error("payload index beyond frame length");

    // a byte taken in the checksum phase closes the frame with a verdict
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && phase_reg == PH_CK
        |=> m_tvalid_reg && (result_reg.event_res == EV_GOOD ||
                             result_reg.event_res == EV_BAD_SUM))
    else $error("checksum byte without frame verdict");

    // every accepted byte produces a pending result next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> m_tvalid_reg)
    else $error("accepted byte without result");

endmodule

`default_nettype wire

// ----- dv/sfpsc_frame_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sfpsc_frame_checker: result predictor and comparator for the frame parser
// Watches the register port and both stream channels, runs its own parse of
// every accepted byte and compares each result transaction field by field.
// ----------------------------------------------------------------------------

module sfpsc_frame_checker
    import sfpsc_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [0:0]           cfg_addr,
    input  wire logic [7:0]           cfg_wdata,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tready,
    input  wire logic [7:0]           s_tdata,    // [7:0] rx_byte
    input  wire logic                 m_tvalid,
    input  wire logic                 m_tready,
    // [2:0] event_res, [10:3] payload_byte, [18:11] payload_index,
    // [26:19] message_id, [34:27] frame_length, rest zero
    input  wire logic [M_TDATA_W-1:0] m_tdata,
    output int                        n_fail,
    output int                        n_pending,
    output int                        n_results,
    output int                        n_good
);

    // parser position within a frame
    typedef enum logic [2:0] {
        PS_HUNT     = 3'd0,
        PS_GOT_SOF  = 3'd1,
        PS_GOT_BID  = 3'd2,
        PS_GOT_MID  = 3'd3,
        PS_PAYLOAD  = 3'd4,
        PS_CHECKSUM = 3'd5
    } parse_state_t;

    parse_state_t parse_st;
    logic [7:0]   msg_id;
    logic [7:0]   decl_len;
    logic [7:0]   pay_idx;
    logic [7:0]   sum_acc;
    logic [7:0]   sof_val;
    logic [7:0]   bid_val;

    result_t expected_results[$];
    int      fail_cnt;
    int      result_cnt;
    int      good_cnt;

    initial begin
        n_fail    = 0;
        n_pending = 0;
        n_results = 0;
        n_good    = 0;
        fail_cnt  = 0;
        result_cnt = 0;
        good_cnt  = 0;
    end

    // one parse step: advances the frame state and returns the result
    function automatic result_t parse_byte(input logic [7:0] c);
        result_t r;
        r = '0;
        r.event_res = EV_NONE;
        sum_acc = sum_acc + c;
        case (parse_st)
            PS_GOT_SOF: begin
                if (c != bid_val) begin
                    r.event_res = EV_BAD_BID;
                    parse_st = PS_HUNT;
                end else begin
                    parse_st = PS_GOT_BID;
                end
            end
            PS_GOT_BID: begin
                msg_id = c;
                parse_st = PS_GOT_MID;
            end
            PS_GOT_MID: begin
                decl_len = c;
                pay_idx = 8'd0;
                if (c > MAX_PAYLOAD) begin
                    r.event_res = EV_TOO_LONG;
                    parse_st = PS_HUNT;
                end else if (c == 8'd0) begin
                    parse_st = PS_CHECKSUM;
                end else begin
                    parse_st = PS_PAYLOAD;
                end
            end
            PS_PAYLOAD: begin
                r.event_res = EV_PAYLOAD;
                r.payload_byte = c;
                r.payload_index = pay_idx;
                pay_idx = pay_idx + 8'd1;
                if (pay_idx >= decl_len)
                    parse_st = PS_CHECKSUM;
            end
            PS_CHECKSUM: begin
                if (sum_acc == 8'd0)
                    r.event_res = EV_GOOD;
                else
                    r.event_res = EV_BAD_SUM;
                parse_st = PS_HUNT;
            end
            default: begin
                // hunting: only the start byte opens a frame
                if (c == sof_val) begin
                    sum_acc = 8'd0;
                    parse_st = PS_GOT_SOF;
                end
            end
        endcase
        r.message_id = msg_id;
        r.frame_length = decl_len;
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t ERROR %s: expected %0d, actual %0d", $time, name, want, got);
            fail_cnt++;
        end
    endtask

    // watch register writes and both channels
    always @(posedge aclk) begin : watch
        result_t want;
        result_t got;
        if (!aresetn) begin
            parse_st = PS_HUNT;
            msg_id   = 8'd0;
            decl_len = 8'd0;
            pay_idx  = 8'd0;
            sum_acc  = 8'd0;
            sof_val  = START_BYTE_RST;
            bid_val  = BUS_ID_BYTE_RST;
            expected_results.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_addr == CFG_START_BYTE)
                    sof_val = cfg_wdata;
                else
                    bid_val = cfg_wdata;
            end
            // result transaction against the oldest expectation
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata[RESULT_W-1:0]);
                if (expected_results.size() == 0) begin
                    $display("%0t ERROR unexpected result: expected none, actual %h",
                             $time, m_tdata);
                    fail_cnt++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("event_res", 32'(want.event_res), 32'(got.event_res));
                    check_field("payload_byte", 32'(want.payload_byte),
                                32'(got.payload_byte));
                    check_field("payload_index", 32'(want.payload_index),
                                32'(got.payload_index));
                    check_field("message_id", 32'(want.message_id), 32'(got.message_id));
                    check_field("frame_length", 32'(want.frame_length),
                                32'(got.frame_length));
                    check_field("padding", 0, 32'(m_tdata[M_TDATA_W-1:RESULT_W]));
                    if (want.event_res == EV_GOOD)
                        good_cnt++;
                    result_cnt++;
                end
            end
            // input transaction
            if (s_tvalid && s_tready)
                expected_results.push_back(parse_byte(s_tdata));
        end
        n_pending <= expected_results.size();
        n_fail    <= fail_cnt;
        n_results <= result_cnt;
        n_good    <= good_cnt;
    end

endmodule

// ----- dv/sync_frame_parser_sum_check_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sync_frame_parser_sum_check_test: stimulus and verdict for the frame parser
// Sends directed and random byte streams made mostly of well-formed frames,
// with broken frames and noise mixed in, under four register settings and
// four idle patterns; the checker instance predicts and compares results.
// ----------------------------------------------------------------------------

module sync_frame_parser_sum_check_test;
    import sfpsc_pkg::*;

    localparam int PHASE_BYTES = 170;

    typedef enum int {
        FR_GOOD,
        FR_BAD_BID,
        FR_TOO_LONG,
        FR_BAD_SUM,
        FR_CUT
    } frame_kind_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [0:0]           cfg_addr  = '0;
    logic [7:0]           cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    int n_fail;
    int n_pending;
    int n_results;
    int n_good;

    int         sender_idle = 0;
    int         recv_stall  = 0;
    int         bytes_sent  = 0;
    logic [7:0] sof_val     = START_BYTE_RST;
    logic [7:0] bid_val     = BUS_ID_BYTE_RST;

    always #5 aclk = ~aclk;

    sync_frame_parser_sum_check u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    sfpsc_frame_checker u_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .n_fail    (n_fail),
        .n_pending (n_pending),
        .n_results (n_results),
        .n_good    (n_good)
    );

    // receiver back-pressure
    always @(posedge aclk)
        m_tready <= ($urandom_range(0, 99) >= recv_stall);

    // one byte transaction, with random idle cycles ahead of it
    task automatic push_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < sender_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        bytes_sent++;
    endtask

    // stop sending until every result has been taken
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        do
            @(posedge aclk);
        while (n_pending != 0);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [7:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        if (idx == CFG_START_BYTE)
            sof_val = val;
        else
            bid_val = val;
    endtask

    // one frame, whole or broken as the kind says
    task automatic send_frame(input frame_kind_t kind, input int len);
        logic [7:0] sum;
        logic [7:0] b;
        int         i;
        int         stop;
        stop = $urandom_range(0, len);
        push_byte(sof_val);
        b = bid_val;
        if (kind == FR_BAD_BID)
            b = bid_val ^ 8'($urandom_range(1, 255));
        push_byte(b);
        if (kind == FR_BAD_BID)
            return;
        b = 8'($urandom);
        push_byte(b);
        sum = bid_val + b;
        if (kind == FR_TOO_LONG) begin
            push_byte(8'd255);
            return;
        end
        push_byte(8'(len));
        sum = sum + 8'(len);
        for (i = 0; i < len; i++) begin
            if (kind == FR_CUT && i == stop)
                return;
            // the start byte value now and then inside the payload
            b = ($urandom_range(0, 7) == 0) ? sof_val : 8'($urandom);
            push_byte(b);
            sum = sum + b;
        end
        if (kind == FR_CUT)
            return;
        b = 8'(0) - sum;
        if (kind == FR_BAD_SUM)
            b = b + 8'($urandom_range(1, 255));
        push_byte(b);
    endtask

    // limit on the whole run
    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial begin
        int         p;
        int         pick;
        int         len;
        logic [7:0] ck;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: ignored bytes while hunting
        push_byte(8'h00);
        push_byte(8'hFF);
        // zero-length frame straight to its checksum
        send_frame(FR_GOOD, 0);
        send_frame(FR_BAD_BID, 0);
        send_frame(FR_TOO_LONG, 0);
        send_frame(FR_BAD_SUM, 1);
        // start byte value inside the payload, message id at its top
        ck = 8'(0) - (bid_val + 8'hFF + 8'd2 + sof_val + 8'hFF);
        push_byte(sof_val);
        push_byte(bid_val);
        push_byte(8'hFF);
        push_byte(8'd2);
        push_byte(sof_val);
        push_byte(8'hFF);
        push_byte(ck);

        for (p = 0; p < 4; p++) begin
            wait_drain();
            repeat (2) @(posedge aclk);
            case (p)
                0: begin
                    sender_idle = 0;
                    recv_stall  = 0;
                end
                1: begin
                    write_reg(CFG_START_BYTE, 8'h00);
                    write_reg(CFG_BUS_ID_BYTE, 8'h00);
                    sender_idle = 46;
                    recv_stall  = 0;
                end
                2: begin
                    write_reg(CFG_START_BYTE, 8'hFF);
                    write_reg(CFG_BUS_ID_BYTE, 8'hFF);
                    sender_idle = 0;
                    recv_stall  = 46;
                end
                default: begin
                    write_reg(CFG_START_BYTE, 8'($urandom));
                    write_reg(CFG_BUS_ID_BYTE, 8'($urandom));
                    sender_idle = 38;
                    recv_stall  = 38;
                end
            endcase
            // the longest payload once, for the top payload index
            if (p == 0)
                send_frame(FR_GOOD, MAX_PAYLOAD);
            while (bytes_sent < 26 + (p + 1) * PHASE_BYTES) begin
                pick = $urandom_range(0, 99);
                len  = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 6)
                                                  : $urandom_range(7, 40);
                if (pick < 62)
                    send_frame(FR_GOOD, len);
                else if (pick < 70)
                    send_frame(FR_BAD_BID, len);
                else if (pick < 76)
                    send_frame(FR_TOO_LONG, len);
                else if (pick < 86)
                    send_frame(FR_BAD_SUM, len);
                else if (pick < 93)
                    send_frame(FR_CUT, len);
                else
                    repeat ($urandom_range(1, 3)) push_byte(8'($urandom));
                if ($urandom_range(0, 39) == 0)
                    wait_drain();
            end
        end

        wait_drain();
        repeat (4) @(posedge aclk);
        $display("covered %0d input bytes, %0d results checked, %0d good frames,",
                 bytes_sent, n_results, n_good);
        $display("four register settings and four idle and stall patterns");
        if (n_fail == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
